>>> rtl/taq_pkg.sv
// ----------------------------------------------------------------------------
// taq_pkg
// Codes and field widths shared by the threshold alarm qualifier.
// ----------------------------------------------------------------------------
package taq_pkg;

	localparam int CMD_W    = 3;
	localparam int VAL_W    = 16;
	localparam int MODE_W   = 3;
	localparam int TAG_W    = 8;
	localparam int STATUS_W = 2;
	localparam int EVENT_W  = 2;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 16;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [VAL_W-1:0]    val_t;
	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [TAG_W-1:0]    tag_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [EVENT_W-1:0]  event_t;
	typedef logic [CFG_AW-1:0]   cfg_addr_t;
	typedef logic [CFG_DW-1:0]   cfg_data_t;

	localparam cmd_t CMD_SAMPLE  = 3'd0;
	localparam cmd_t CMD_ENABLE  = 3'd1;
	localparam cmd_t CMD_DISABLE = 3'd2;
	localparam cmd_t CMD_CLEAR   = 3'd3;
	localparam cmd_t CMD_RESTART = 3'd4;

	localparam status_t ST_NORMAL   = 2'd0;
	localparam status_t ST_ACTIVE   = 2'd1;
	localparam status_t ST_DISABLED = 2'd2;

	localparam event_t EV_NONE      = 2'd0;
	localparam event_t EV_TRIGGERED = 2'd1;
	localparam event_t EV_RECOVERED = 2'd2;

	localparam mode_t MODE_GE = 3'd0;
	localparam mode_t MODE_GT = 3'd1;
	localparam mode_t MODE_LE = 3'd2;
	localparam mode_t MODE_LT = 3'd3;
	localparam mode_t MODE_EQ = 3'd4;
	localparam mode_t MODE_NE = 3'd5;

	localparam cfg_addr_t REG_COMPARE_MODE    = 3'd0;
	localparam cfg_addr_t REG_THRESHOLD       = 3'd1;
	localparam cfg_addr_t REG_HYSTERESIS      = 3'd2;
	localparam cfg_addr_t REG_TRIGGER_SAMPLES = 3'd3;
	localparam cfg_addr_t REG_RECOVER_SAMPLES = 3'd4;
	localparam cfg_addr_t REG_ALARM_TAG       = 3'd5;

endpackage

>>> rtl/threshold_alarm_qualifier.sv
// ----------------------------------------------------------------------------
// threshold_alarm_qualifier
// Debounced threshold alarm with hysteresis, trigger count and event tagging.
// ----------------------------------------------------------------------------
// Each accepted command word yields exactly one result word in the next cycle.
// The block takes a new word in every cycle: all of the compare, counter and
// status update for a word is done in one pass between the input port and the
// result register, and in_ready stays high whenever the result register is
// empty or is being taken in the same cycle. Configuration is written through
// a plain write port and should be changed only while no result is pending.
// ----------------------------------------------------------------------------
module threshold_alarm_qualifier (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  taq_pkg::cfg_addr_t cfg_addr,
	input  taq_pkg::cfg_data_t cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  taq_pkg::cmd_t      cmd,
	input  taq_pkg::val_t      sample_value,
	output logic               out_valid,
	input  logic               out_ready,
	output taq_pkg::status_t   alarm_status,
	output taq_pkg::event_t    event_res,
	output taq_pkg::tag_t      event_tag,
	output taq_pkg::val_t      trigger_total
);
	import taq_pkg::*;

	mode_t   mode_q;
	val_t    thresh_q;
	val_t    hyst_q;
	val_t    trig_len_q;
	val_t    recov_len_q;
	tag_t    tag_q;

	status_t status_q;
	logic    enabled_q;
	val_t    match_q;
	val_t    recov_q;
	val_t    trig_q;

	logic    out_valid_q;
	status_t out_status_q;
	event_t  out_event_q;
	tag_t    out_tag_q;
	val_t    out_total_q;

	status_t status_d;
	logic    enabled_d;
	val_t    match_d;
	val_t    recov_d;
	val_t    trig_d;
	event_t  ev_d;
	logic    cond_met;
	logic    recov_met;
	val_t    low_bound;
	val_t    high_bound;
	val_t    match_inc;
	val_t    recov_inc;
	logic    in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			thresh_q    <= '0;
			hyst_q      <= '0;
			trig_len_q  <= '0;
			recov_len_q <= '0;
			tag_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_COMPARE_MODE:    mode_q      <= cfg_wdata[MODE_W-1:0];
				REG_THRESHOLD:       thresh_q    <= cfg_wdata[VAL_W-1:0];
				REG_HYSTERESIS:      hyst_q      <= cfg_wdata[VAL_W-1:0];
				REG_TRIGGER_SAMPLES: trig_len_q  <= cfg_wdata[VAL_W-1:0];
				REG_RECOVER_SAMPLES: recov_len_q <= cfg_wdata[VAL_W-1:0];
				REG_ALARM_TAG:       tag_q       <= cfg_wdata[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	assign low_bound  = thresh_q - hyst_q;
	assign high_bound = thresh_q + hyst_q;
	assign match_inc  = match_q + 1'b1;
	assign recov_inc  = recov_q + 1'b1;

	always_comb begin
		case (mode_q)
			MODE_GE: cond_met = sample_value >= thresh_q;
			MODE_GT: cond_met = sample_value >  thresh_q;
			MODE_LE: cond_met = sample_value <= thresh_q;
			MODE_LT: cond_met = sample_value <  thresh_q;
			MODE_EQ: cond_met = sample_value == thresh_q;
			MODE_NE: cond_met = sample_value != thresh_q;
			default: cond_met = 1'b0;
		endcase
		case (mode_q) inside
			MODE_GE, MODE_GT: recov_met = sample_value < low_bound;
			MODE_LE, MODE_LT: recov_met = sample_value > high_bound;
			MODE_EQ:          recov_met = sample_value != thresh_q;
			MODE_NE:          recov_met = sample_value == thresh_q;
			default:          recov_met = 1'b0;
		endcase
	end

	always_comb begin
		status_d  = status_q;
		enabled_d = enabled_q;
		match_d   = match_q;
		recov_d   = recov_q;
		trig_d    = trig_q;
		ev_d      = EV_NONE;
		unique case (cmd)
			CMD_SAMPLE: begin
				if (enabled_q) begin
					if (status_q == ST_NORMAL) begin
						if (cond_met) begin
							match_d = match_inc;
							if (match_inc >= trig_len_q) begin
								status_d = ST_ACTIVE;
								match_d  = '0;
								recov_d  = '0;
								trig_d   = trig_q + 1'b1;
								ev_d     = EV_TRIGGERED;
							end
						end else begin
							match_d = '0;
						end
					end else if (status_q == ST_ACTIVE) begin
						if (recov_met) begin
							recov_d = recov_inc;
							if (recov_inc >= recov_len_q) begin
								status_d = ST_NORMAL;
								match_d  = '0;
								recov_d  = '0;
								ev_d     = EV_RECOVERED;
							end
						end else begin
							recov_d = '0;
						end
					end
				end
			end
			CMD_ENABLE: begin
				enabled_d = 1'b1;
				if (status_q == ST_DISABLED) begin
					status_d = ST_NORMAL;
				end
			end
			CMD_DISABLE: begin
				enabled_d = 1'b0;
				status_d  = ST_DISABLED;
				match_d   = '0;
				recov_d   = '0;
			end
			CMD_CLEAR: begin
				status_d = ST_NORMAL;
				match_d  = '0;
				recov_d  = '0;
			end
			CMD_RESTART: begin
				status_d  = ST_NORMAL;
				enabled_d = 1'b1;
				match_d   = '0;
				recov_d   = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= ST_NORMAL;
			enabled_q <= 1'b0;
			match_q   <= '0;
			recov_q   <= '0;
			trig_q    <= '0;
		end else if (in_fire) begin
			status_q  <= status_d;
			enabled_q <= enabled_d;
			match_q   <= match_d;
			recov_q   <= recov_d;
			trig_q    <= trig_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_status_q <= status_d;
			out_event_q  <= ev_d;
			out_tag_q    <= (ev_d != EV_NONE) ? tag_q : '0;
			out_total_q  <= trig_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign alarm_status  = out_status_q;
	assign event_res     = out_event_q;
	assign event_tag     = out_tag_q;
	assign trigger_total = out_total_q;

	// A disabled status always comes with the enable flag cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		status_q == ST_DISABLED |-> !enabled_q)
	else $error("disabled status while enabled");

	// Qualification counters only run in the status that uses them.
	assert property (@(posedge clk) disable iff (!arst_n)
		(match_q == '0 || status_q == ST_NORMAL) &&
		(recov_q == '0 || status_q == ST_ACTIVE))
	else $error("qualification counter running in wrong status");

	// The trigger count moves only with a trigger event.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && ev_d == EV_TRIGGERED) |=> $stable(trig_q))
	else $error("trigger count changed without a trigger");

	// A trigger reports an active status and the new count.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && ev_d == EV_TRIGGERED |=>
		out_valid && alarm_status == ST_ACTIVE && trigger_total == trig_q)
	else $error("trigger result inconsistent");

endmodule

>>> tb/threshold_alarm_qualifier_test.sv
// ----------------------------------------------------------------------------
// threshold_alarm_qualifier_test
// Self-checking testbench for the debounced threshold alarm qualifier.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the registers and the alarm state
// and works out the result word for every accepted command word. Each result
// word taken from the block is compared field by field with the oldest
// prediction. A short directed part covers the edge cases; random phases
// then reprogram all registers while the block is idle and send mostly samples
// around the threshold and recovery bound, with random stalls in most phases.
// ----------------------------------------------------------------------------
module threshold_alarm_qualifier_test;
	timeunit 1ns;
	timeprecision 1ps;
	import taq_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 22;
	localparam int PHASE_WORDS = 50;

	localparam cmd_t  CMD_BAD_FIRST = 3'd5;
	localparam cmd_t  CMD_BAD_LAST  = 3'd7;
	localparam mode_t MODE_OFF_A    = 3'd6;
	localparam mode_t MODE_OFF_B    = 3'd7;

	typedef struct packed {
		status_t status;
		event_t  evt;
		tag_t    tag;
		val_t    total;
	} alarm_result_t;

	class alarm_tracker;
		mode_t   mode      = MODE_GE;
		val_t    thr       = '0;
		val_t    hyst      = '0;
		val_t    trig_len  = '0;
		val_t    rec_len   = '0;
		tag_t    tag       = '0;
		status_t status    = ST_NORMAL;
		bit      enabled   = 1'b0;
		val_t    match_cnt = '0;
		val_t    rec_cnt   = '0;
		val_t    triggers  = '0;
		alarm_result_t pending[$];
		int      mismatches = 0;

		function void set_reg(cfg_addr_t idx, cfg_data_t d);
			case (idx)
				REG_COMPARE_MODE:    mode     = d[MODE_W-1:0];
				REG_THRESHOLD:       thr      = d;
				REG_HYSTERESIS:      hyst     = d;
				REG_TRIGGER_SAMPLES: trig_len = d;
				REG_RECOVER_SAMPLES: rec_len  = d;
				REG_ALARM_TAG:       tag      = d[TAG_W-1:0];
				default: ;
			endcase
		endfunction

		function bit alarm_cond(val_t v);
			case (mode)
				MODE_GE: return v >= thr;
				MODE_GT: return v > thr;
				MODE_LE: return v <= thr;
				MODE_LT: return v < thr;
				MODE_EQ: return v == thr;
				MODE_NE: return v != thr;
				default: return 1'b0;
			endcase
		endfunction

		function bit recovery_cond(val_t v);
			val_t lower;
			val_t upper;
			lower = thr - hyst;
			upper = thr + hyst;
			case (mode)
				MODE_GE, MODE_GT: return v < lower;
				MODE_LE, MODE_LT: return v > upper;
				MODE_EQ: return v != thr;
				MODE_NE: return v == thr;
				default: return 1'b0;
			endcase
		endfunction

		function void note_command(cmd_t c, val_t v);
			event_t evt;
			evt = EV_NONE;
			case (c)
				CMD_SAMPLE: begin
					if (enabled && status == ST_NORMAL) begin
						if (alarm_cond(v)) begin
							match_cnt = match_cnt + 1'b1;
							if (match_cnt >= trig_len) begin
								status    = ST_ACTIVE;
								match_cnt = '0;
								rec_cnt   = '0;
								triggers  = triggers + 1'b1;
								evt       = EV_TRIGGERED;
							end
						end else begin
							match_cnt = '0;
						end
					end else if (enabled && status == ST_ACTIVE) begin
						if (recovery_cond(v)) begin
							rec_cnt = rec_cnt + 1'b1;
							if (rec_cnt >= rec_len) begin
								status    = ST_NORMAL;
								match_cnt = '0;
								rec_cnt   = '0;
								evt       = EV_RECOVERED;
							end
						end else begin
							rec_cnt = '0;
						end
					end
				end
				CMD_ENABLE: begin
					enabled = 1'b1;
					if (status == ST_DISABLED)
						status = ST_NORMAL;
				end
				CMD_DISABLE: begin
					enabled   = 1'b0;
					status    = ST_DISABLED;
					match_cnt = '0;
					rec_cnt   = '0;
				end
				CMD_CLEAR: begin
					status    = ST_NORMAL;
					match_cnt = '0;
					rec_cnt   = '0;
				end
				CMD_RESTART: begin
					status    = ST_NORMAL;
					match_cnt = '0;
					rec_cnt   = '0;
					enabled   = 1'b1;
				end
				default: ;
			endcase
			pending.push_back(alarm_result_t'{status, evt,
				(evt != EV_NONE) ? tag : tag_t'(0), triggers});
		endfunction

		function void check_result(alarm_result_t got);
			alarm_result_t want;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: status %0d, event %0d",
					got.status, got.evt);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$error("alarm_status expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.evt !== want.evt) begin
				$error("event_res expected %0d, got %0d", want.evt, got.evt);
				mismatches++;
			end
			if (got.tag !== want.tag) begin
				$error("event_tag expected %0d, got %0d", want.tag, got.tag);
				mismatches++;
			end
			if (got.total !== want.total) begin
				$error("trigger_total expected %0d, got %0d", want.total, got.total);
				mismatches++;
			end
		endfunction
	endclass

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      cfg_we       = 1'b0;
	cfg_addr_t cfg_addr     = '0;
	cfg_data_t cfg_wdata    = '0;
	logic      in_valid     = 1'b0;
	logic      in_ready;
	cmd_t      cmd          = CMD_SAMPLE;
	val_t      sample_value = '0;
	logic      out_valid;
	logic      out_ready    = 1'b0;
	status_t   alarm_status;
	event_t    event_res;
	tag_t      event_tag;
	val_t      trigger_total;

	alarm_tracker tracker;
	bit   tx_gaps = 1'b1;
	bit   rx_gaps = 1'b1;
	int   words_sent = 0;
	int   results_seen = 0;
	int   settings_count = 0;
	int   quiet_cycles = 0;
	val_t cur_thr = '0;
	val_t cur_hyst = '0;

	threshold_alarm_qualifier DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.alarm_status (alarm_status),
		.event_res    (event_res),
		.event_tag    (event_tag),
		.trigger_total(trigger_total)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= arst_n && (!rx_gaps || $urandom_range(0, 99) >= 16);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.check_result(alarm_result_t'{alarm_status, event_res, event_tag,
				trigger_total});
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("[threshold_alarm_qualifier] ERROR");
				$finish;
			end
		end
	end

	// All driving tasks start and end just after a falling edge.
	task automatic send_word(cmd_t word_cmd, val_t word_val);
		while (tx_gaps && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= word_cmd;
		sample_value <= word_val;
		do @(posedge clk); while (!in_ready);
		tracker.note_command(word_cmd, word_val);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic program_regs(cfg_data_t mode_d, cfg_data_t thr_d, cfg_data_t hyst_d,
		cfg_data_t trig_d, cfg_data_t rec_d, cfg_data_t tag_d);
		cfg_data_t vals[6];
		vals = '{mode_d, thr_d, hyst_d, trig_d, rec_d, tag_d};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= cfg_addr_t'(i);
			cfg_wdata <= vals[i];
			tracker.set_reg(cfg_addr_t'(i), vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_thr  = thr_d;
		cur_hyst = hyst_d;
		settings_count++;
	endtask

	initial begin
		cmd_t c;
		val_t v;
		int   pick;
		tracker = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Samples before any enable are ignored, as are the unused command codes.
		send_word(CMD_SAMPLE, 16'hFFFF);
		send_word(CMD_SAMPLE, 16'h0000);
		send_word(CMD_BAD_FIRST, 16'h5555);
		send_word(CMD_BAD_FIRST + 1'b1, 16'hAAAA);
		send_word(CMD_BAD_LAST, 16'hFFFF);
		settle();

		program_regs(cfg_data_t'(MODE_GE), 16'h8000, 16'h0100, 16'd2, 16'd1, 16'h00A5);
		send_word(CMD_ENABLE, 16'h0000);
		send_word(CMD_SAMPLE, 16'h8000);
		send_word(CMD_SAMPLE, 16'h7FFF);
		send_word(CMD_SAMPLE, 16'hFFFF);
		send_word(CMD_SAMPLE, 16'h8000);
		send_word(CMD_SAMPLE, 16'h7F00);
		send_word(CMD_SAMPLE, 16'h7EFF);
		send_word(CMD_DISABLE, 16'h0000);
		send_word(CMD_SAMPLE, 16'hFFFF);
		send_word(CMD_ENABLE, 16'h0000);
		send_word(CMD_CLEAR, 16'h0000);
		send_word(CMD_RESTART, 16'hFFFF);
		settle();

		// Zero lengths with a recovery bound that wraps past the top.
		program_regs(cfg_data_t'(MODE_LE), 16'hFFFF, 16'h0001, 16'd0, 16'd0, 16'h00FF);
		send_word(CMD_SAMPLE, 16'h0000);
		send_word(CMD_SAMPLE, 16'h0001);
		send_word(CMD_SAMPLE, 16'hFFFF);
		settle();

		program_regs(cfg_data_t'(MODE_OFF_A), 16'h0000, 16'hFFFF, 16'd0, 16'd0, 16'h0000);
		send_word(CMD_SAMPLE, 16'h0000);
		send_word(CMD_SAMPLE, 16'hFFFF);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			tx_gaps = (p < 6 || p > 8);
			rx_gaps = tx_gaps;
			pick = $urandom_range(0, 9);
			program_regs(
				{13'($urandom_range(0, 8191)),
					(p < 8) ? mode_t'(p) : mode_t'($urandom_range(0, 7))},
				(pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : cfg_data_t'($urandom),
				($urandom_range(0, 9) == 0) ? 16'hFFFF :
					($urandom_range(0, 5) == 0) ? cfg_data_t'($urandom) :
					cfg_data_t'($urandom_range(0, 64)),
				($urandom_range(0, 11) == 0) ? 16'hFFFF : cfg_data_t'($urandom_range(0, 6)),
				($urandom_range(0, 11) == 0) ? 16'hFFFF : cfg_data_t'($urandom_range(0, 6)),
				cfg_data_t'($urandom));
			send_word(CMD_RESTART, val_t'($urandom));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 84)
					c = CMD_SAMPLE;
				else if (pick < 88)
					c = CMD_ENABLE;
				else if (pick < 91)
					c = CMD_RESTART;
				else if (pick < 94)
					c = CMD_CLEAR;
				else if (pick < 96)
					c = CMD_DISABLE;
				else
					c = cmd_t'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
				case ($urandom_range(0, 7))
					0: v = val_t'($urandom);
					1: v = cur_thr;
					2: v = cur_thr - cur_hyst + val_t'($urandom_range(0, 6)) - 16'd3;
					3: v = cur_thr + cur_hyst + val_t'($urandom_range(0, 6)) - 16'd3;
					4: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					default: v = cur_thr + val_t'($urandom_range(0, 40)) - 16'd20;
				endcase
				send_word(c, v);
			end
			settle();
		end

		repeat (4) @(negedge clk);
		$display("Sent %0d command words and checked %0d result words over %0d settings,",
			words_sent, results_seen, settings_count);
		$display("covering all compare modes, every command and the unused codes.");
		if (tracker.mismatches == 0)
			$display("[threshold_alarm_qualifier] OK");
		else
			$display("[threshold_alarm_qualifier] ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/taq_pkg.sv
rtl/threshold_alarm_qualifier.sv
tb/threshold_alarm_qualifier_test.sv
